// ----- design/srrw_pkg.sv -----
// Shared types and constants for the selective-repeat receive window.
// Holds the default sizes, stream field layout, packet and result codes
// and the control state type. No dependencies.
`default_nettype none

package srrw_pkg;

    // Default sizes
    localparam int SEQ_SPACE_DEF     = 32;
    localparam int WINDOW_DEF        = 16;
    localparam int PAYLOAD_BYTES_DEF = 8;

    // Fixed field widths
    localparam int CONN_W  = 8;
    localparam int SEQ_F_W = 5;
    localparam int RETRY_W = 8;
    localparam int PAY_F_W = 64;
    localparam int LEN_W   = 4;

    // Slave tdata layout, lowest bit first
    localparam int S_CONN_LSB  = 0;
    localparam int S_SEQ_LSB   = S_CONN_LSB + CONN_W;
    localparam int S_RETRY_LSB = S_SEQ_LSB + SEQ_F_W;
    localparam int S_PAY_LSB   = S_RETRY_LSB + RETRY_W;
    localparam int S_LEN_LSB   = S_PAY_LSB + PAY_F_W;
    localparam int S_QFULL_BIT = S_LEN_LSB + LEN_W;
    localparam int S_TDATA_W   = ((S_QFULL_BIT + 1 + 7) / 8) * 8;

    // Master tdata layout, lowest bit first
    localparam int M_SEQ_LSB    = 0;
    localparam int M_RETRY_LSB  = M_SEQ_LSB + SEQ_F_W;
    localparam int M_PAY_LSB    = M_RETRY_LSB + RETRY_W;
    localparam int M_LEN_LSB    = M_PAY_LSB + PAY_F_W;
    localparam int M_CLOSED_BIT = M_LEN_LSB + LEN_W;
    localparam int M_TDATA_W    = ((M_CLOSED_BIT + 1 + 7) / 8) * 8;

    // Packet kinds (s_tuser)
    localparam logic PKT_DATA  = 1'b0;
    localparam logic PKT_CLOSE = 1'b1;

    // Result kinds (m_tuser)
    localparam logic RES_ACK     = 1'b0;
    localparam logic RES_DELIVER = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_ACK,
        ST_STEP,
        ST_DELIV
    } state_t;

endpackage

`default_nettype wire

// ----- design/selective_repeat_receive_window_unit.sv -----
// Receive side of a selective-repeat link: window state, slot buffer and
// in-order delivery sequencer.
// Depends on srrw_pkg for sizes, stream layout, codes and the state type.
`default_nettype none

// Usage
//   Packets enter as beats on the s_ channel (tuser = packet kind, tdata =
//   connection id, seq, retry count, payload, length, queue-full flag).
//   Results leave as beats on the m_ channel: an acknowledgement first, then
//   zero or more in-order deliveries; tlast marks the final beat of a packet.
//   cfg_we/cfg_wdata load the accepted connection id; write it only while idle.
//   One packet is handled at a time. A dropped packet leaves from the EVAL
//   state; an acknowledged one goes on to ACK, then through STEP and DELIV
//   for each delivered slot (one slot buffer read and one output load per
//   slot); up to WINDOW slots are delivered per packet. The first result
//   beat is loaded into the output register in ACK, after EVAL.
//   The slot buffer is a synchronous RAM with one write and one read port;
//   the expected flags live in a flop vector read at one address per cycle.
//   Reset clears the window to its start position, reopens the link and
//   empties the output register; the slot buffer keeps its contents.
//   When m_tready is low the result beat holds in the output register and
//   the sequencer waits; no input beat is taken until the packet finishes.
module selective_repeat_receive_window_unit #(
    parameter int SEQ_SPACE     = srrw_pkg::SEQ_SPACE_DEF,
    parameter int WINDOW        = srrw_pkg::WINDOW_DEF,
    parameter int PAYLOAD_BYTES = srrw_pkg::PAYLOAD_BYTES_DEF
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    // Configuration
    input  wire                            cfg_we,
    input  wire  [srrw_pkg::CONN_W-1:0]    cfg_wdata,
    // Packet input
    input  wire                            s_tvalid,
    output logic                           s_tready,
    // tdata: packet_conn, seq, retry_count, payload, payload_len, queue_full
    input  wire  [srrw_pkg::S_TDATA_W-1:0] s_tdata,
    // tuser: packet_kind
    input  wire                            s_tuser,
    // Result output
    output logic                           m_tvalid,
    input  wire                            m_tready,
    // tdata: out_seq, out_retry, out_payload, out_len, link_closed
    output logic [srrw_pkg::M_TDATA_W-1:0] m_tdata,
    // tuser: result_kind
    output logic                           m_tuser,
    output logic                           m_tlast
);

    localparam int SEQ_W    = (SEQ_SPACE > 1) ? $clog2(SEQ_SPACE) : 1;
    localparam int DATA_W   = 8 * PAYLOAD_BYTES;
    localparam int SLOT_W   = DATA_W + srrw_pkg::LEN_W;
    localparam int CNT_W    = $clog2(WINDOW + 1);
    localparam int EDGE_RST = WINDOW % SEQ_SPACE;
    localparam int MOD_W    = 11;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    srrw_pkg::state_t state_reg, state_next;

    logic [srrw_pkg::CONN_W-1:0]  conn_id_reg;

    // Latched packet
    logic                         kind_reg;
    logic [srrw_pkg::CONN_W-1:0]  conn_reg;
    logic [SEQ_W-1:0]             seq_reg;
    logic [srrw_pkg::RETRY_W-1:0] retry_reg;
    logic [DATA_W-1:0]            pay_reg;
    logic [srrw_pkg::LEN_W-1:0]   len_reg;
    logic                         qfull_reg;

    // Window state
    logic [SEQ_SPACE-1:0] exp_reg, exp_next;
    logic [SEQ_W-1:0]     lio_reg, lio_next;
    logic [SEQ_W-1:0]     edge_reg, edge_next;
    logic                 closed_reg, closed_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 slide_reg, slide_next;

    // Slot buffer
    logic [SLOT_W-1:0] slot_mem [SEQ_SPACE];
    logic [SLOT_W-1:0] slot_rd_reg;
    logic              slot_we;
    logic              slot_re;

    // Output register
    logic                         m_valid_reg, m_valid_next;
    logic                         m_kind_reg, m_kind_next;
    logic [srrw_pkg::SEQ_F_W-1:0] m_seq_reg, m_seq_next;
    logic [srrw_pkg::RETRY_W-1:0] m_retry_reg, m_retry_next;
    logic [srrw_pkg::PAY_F_W-1:0] m_pay_reg, m_pay_next;
    logic [srrw_pkg::LEN_W-1:0]   m_len_reg, m_len_next;
    logic                         m_closed_reg, m_closed_next;
    logic                         m_last_reg, m_last_next;

    // ------------------------------------------------------------------
    // Input unpack: reduce seq into the sequence space, saturate the
    // length and zero the bytes past it.
    // ------------------------------------------------------------------
    logic [MOD_W-1:0]           seq_mod;
    logic [SEQ_W-1:0]           in_seq;
    logic [srrw_pkg::LEN_W-1:0] in_len_raw;
    logic [srrw_pkg::LEN_W-1:0] in_len;
    logic [DATA_W-1:0]          in_pay_raw;
    logic [DATA_W-1:0]          in_pay;

    always_comb begin
        seq_mod = MOD_W'(s_tdata[srrw_pkg::S_SEQ_LSB +: srrw_pkg::SEQ_F_W]);
        for (int k = 2; k >= 0; k--) begin
            if (seq_mod >= MOD_W'(SEQ_SPACE << k)) begin
                seq_mod = seq_mod - MOD_W'(SEQ_SPACE << k);
            end
        end
        in_seq = SEQ_W'(seq_mod);
    end

    assign in_len_raw = s_tdata[srrw_pkg::S_LEN_LSB +: srrw_pkg::LEN_W];
    assign in_len     = (in_len_raw > srrw_pkg::LEN_W'(PAYLOAD_BYTES))
                      ? srrw_pkg::LEN_W'(PAYLOAD_BYTES) : in_len_raw;
    assign in_pay_raw = s_tdata[srrw_pkg::S_PAY_LSB +: DATA_W];

    always_comb begin
        for (int b = 0; b < PAYLOAD_BYTES; b++) begin
            in_pay[8*b +: 8] = (srrw_pkg::LEN_W'(b) < in_len) ? in_pay_raw[8*b +: 8] : 8'h00;
        end
    end

    // ------------------------------------------------------------------
    // Window arithmetic
    // ------------------------------------------------------------------
    logic [SEQ_W-1:0] lio_inc;
    logic [SEQ_W-1:0] edge_inc;
    logic [SEQ_W:0]   span_raw;
    logic [SEQ_W:0]   dist_raw;
    logic [SEQ_W-1:0] span;
    logic [SEQ_W-1:0] seq_dist;
    logic             in_win;
    logic [SEQ_W-1:0] exp_addr;
    logic             exp_bit;
    logic             conn_ok;
    logic             out_free;
    logic             deliv_last;

    assign lio_inc  = (lio_reg == SEQ_W'(SEQ_SPACE - 1)) ? '0 : lio_reg + 1'b1;
    assign edge_inc = (edge_reg == SEQ_W'(SEQ_SPACE - 1)) ? '0 : edge_reg + 1'b1;

    // Distances past last_in_order, wrapped into the sequence space
    assign span_raw = {1'b0, edge_reg} - {1'b0, lio_reg};
    assign dist_raw = {1'b0, seq_reg} - {1'b0, lio_reg};
    assign span = span_raw[SEQ_W] ? SEQ_W'(span_raw + (SEQ_W+1)'(SEQ_SPACE))
                                  : span_raw[SEQ_W-1:0];
    assign seq_dist = dist_raw[SEQ_W] ? SEQ_W'(dist_raw + (SEQ_W+1)'(SEQ_SPACE))
                                      : dist_raw[SEQ_W-1:0];
    // An empty span opens the whole sequence space
    assign in_win = (span == '0) || ((seq_dist != '0) && (seq_dist <= span));

    // One read of the expected flags per cycle
    assign exp_addr = (state_reg == srrw_pkg::ST_EVAL) ? seq_reg : lio_inc;
    assign exp_bit  = exp_reg[exp_addr];

    assign conn_ok    = (conn_reg == conn_id_reg);
    assign out_free   = !m_valid_reg || m_tready;
    // Stop after WINDOW slots or at the first gap
    assign deliv_last = (cnt_reg == CNT_W'(WINDOW)) || exp_bit;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            srrw_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = srrw_pkg::ST_EVAL;
                end
            end
            srrw_pkg::ST_EVAL: begin
                if (!conn_ok) begin
                    state_next = srrw_pkg::ST_IDLE;
                end else if (kind_reg == srrw_pkg::PKT_DATA && (closed_reg || qfull_reg)) begin
                    state_next = srrw_pkg::ST_IDLE;
                end else begin
                    state_next = srrw_pkg::ST_ACK;
                end
            end
            srrw_pkg::ST_ACK: begin
                if (out_free) begin
                    state_next = slide_reg ? srrw_pkg::ST_STEP : srrw_pkg::ST_IDLE;
                end
            end
            srrw_pkg::ST_STEP: begin
                state_next = srrw_pkg::ST_DELIV;
            end
            srrw_pkg::ST_DELIV: begin
                if (out_free) begin
                    state_next = deliv_last ? srrw_pkg::ST_IDLE : srrw_pkg::ST_STEP;
                end
            end
            default: begin
                state_next = srrw_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Outputs and datapath updates
    // ------------------------------------------------------------------
    always_comb begin
        s_tready      = 1'b0;
        slot_we       = 1'b0;
        slot_re       = 1'b0;
        exp_next      = exp_reg;
        lio_next      = lio_reg;
        edge_next     = edge_reg;
        closed_next   = closed_reg;
        cnt_next      = cnt_reg;
        slide_next    = slide_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_kind_next   = m_kind_reg;
        m_seq_next    = m_seq_reg;
        m_retry_next  = m_retry_reg;
        m_pay_next    = m_pay_reg;
        m_len_next    = m_len_reg;
        m_closed_next = m_closed_reg;
        m_last_next   = m_last_reg;

        unique case (state_reg)
            srrw_pkg::ST_IDLE: begin
                s_tready = 1'b1;
            end
            srrw_pkg::ST_EVAL: begin
                cnt_next   = '0;
                slide_next = 1'b0;
                if (conn_ok) begin
                    if (kind_reg == srrw_pkg::PKT_CLOSE) begin
                        if (in_win) begin
                            exp_next[seq_reg] = 1'b0;
                            closed_next       = 1'b1;
                        end
                    end else if (!closed_reg && !qfull_reg && in_win && exp_bit) begin
                        // Buffer once; slide when it fills the next hole
                        exp_next[seq_reg] = 1'b0;
                        slot_we           = 1'b1;
                        slide_next        = (seq_reg == lio_inc);
                    end
                end
            end
            srrw_pkg::ST_ACK: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_kind_next   = srrw_pkg::RES_ACK;
                    m_seq_next    = srrw_pkg::SEQ_F_W'(seq_reg);
                    m_retry_next  = retry_reg;
                    m_pay_next    = '0;
                    m_len_next    = '0;
                    m_closed_next = closed_reg;
                    m_last_next   = !slide_reg;
                end
            end
            srrw_pkg::ST_STEP: begin
                // Advance the window by one slot; a set at the new edge wins
                slot_re            = 1'b1;
                lio_next           = lio_inc;
                edge_next          = edge_inc;
                exp_next[lio_inc]  = 1'b0;
                exp_next[edge_inc] = 1'b1;
                cnt_next           = cnt_reg + 1'b1;
            end
            srrw_pkg::ST_DELIV: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_kind_next   = srrw_pkg::RES_DELIVER;
                    m_seq_next    = srrw_pkg::SEQ_F_W'(lio_reg);
                    m_retry_next  = '0;
                    m_pay_next    = srrw_pkg::PAY_F_W'(slot_rd_reg[DATA_W-1:0]);
                    m_len_next    = slot_rd_reg[DATA_W +: srrw_pkg::LEN_W];
                    m_closed_next = closed_reg;
                    m_last_next   = deliv_last;
                end
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Slot buffer: written at the packet's seq, read at the slide position
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (slot_we) begin
            slot_mem[seq_reg] <= {len_reg, pay_reg};
        end
        if (slot_re) begin
            slot_rd_reg <= slot_mem[lio_inc];
        end
    end

    // ------------------------------------------------------------------
    // Packet latch, output register fields and sequencer counters (no reset)
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            kind_reg  <= s_tuser;
            conn_reg  <= s_tdata[srrw_pkg::S_CONN_LSB +: srrw_pkg::CONN_W];
            seq_reg   <= in_seq;
            retry_reg <= s_tdata[srrw_pkg::S_RETRY_LSB +: srrw_pkg::RETRY_W];
            pay_reg   <= in_pay;
            len_reg   <= in_len;
            qfull_reg <= s_tdata[srrw_pkg::S_QFULL_BIT];
        end
        m_kind_reg   <= m_kind_next;
        m_seq_reg    <= m_seq_next;
        m_retry_reg  <= m_retry_next;
        m_pay_reg    <= m_pay_next;
        m_len_reg    <= m_len_next;
        m_closed_reg <= m_closed_next;
        m_last_reg   <= m_last_next;
        cnt_reg      <= cnt_next;
        slide_reg    <= slide_next;
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= srrw_pkg::ST_IDLE;
            conn_id_reg <= '0;
            lio_reg     <= '0;
            edge_reg    <= SEQ_W'(EDGE_RST);
            closed_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int j = 0; j < SEQ_SPACE; j++) begin
                exp_reg[j] <= (WINDOW >= SEQ_SPACE) || (j >= 1 && j <= WINDOW);
            end
        end else begin
            state_reg   <= state_next;
            lio_reg     <= lio_next;
            edge_reg    <= edge_next;
            closed_reg  <= closed_next;
            m_valid_reg <= m_valid_next;
            exp_reg     <= exp_next;
            if (cfg_we) begin
                conn_id_reg <= cfg_wdata;
            end
        end
    end

    // ------------------------------------------------------------------
    // Port drive
    // ------------------------------------------------------------------
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

    always_comb begin
        m_tdata = '0;
        m_tdata[srrw_pkg::M_SEQ_LSB +: srrw_pkg::SEQ_F_W]   = m_seq_reg;
        m_tdata[srrw_pkg::M_RETRY_LSB +: srrw_pkg::RETRY_W] = m_retry_reg;
        m_tdata[srrw_pkg::M_PAY_LSB +: srrw_pkg::PAY_F_W]   = m_pay_reg;
        m_tdata[srrw_pkg::M_LEN_LSB +: srrw_pkg::LEN_W]     = m_len_reg;
        m_tdata[srrw_pkg::M_CLOSED_BIT]                     = m_closed_reg;
    end

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Self-checking bench for the selective-repeat receive window unit: directed
// packets, then random traffic checked beat by beat against a window predictor.
// Depends on srrw_pkg and selective_repeat_receive_window_unit.
`timescale 1ns / 1ps

module tb_top;

    import srrw_pkg::*;

    localparam int SEQ_SPACE     = SEQ_SPACE_DEF;
    localparam int WINDOW        = WINDOW_DEF;
    localparam int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF;
    localparam int GAP_MAX       = 13;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 12;
    localparam int LIMIT_CYCLES  = 600000;
    localparam int REPORT_MAX    = 10;

    // One packet as the sender sees it
    typedef struct packed {
        logic        kind;
        logic [7:0]  conn;
        logic [4:0]  seq;
        logic [7:0]  retry;
        logic [63:0] payload;
        logic [3:0]  len;
        logic        qfull;
    } packet_t;

    // One result beat, fields in output order
    typedef struct packed {
        logic        kind;
        logic [4:0]  seq;
        logic [7:0]  retry;
        logic [63:0] payload;
        logic [3:0]  len;
        logic        closed;
        logic        last;
    } result_t;

    // Directed row: a packet, plus an expectation typed in by hand where the
    // outcome is obvious (typed_ack = 1 means one plain ack on an open link,
    // typed_ack = 0 means the packet is dropped).
    typedef struct packed {
        packet_t pkt;
        logic    typed;
        logic    typed_ack;
    } stim_row_t;

    localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    // Rows run on the reset connection id 0, window starts at 1..16.
    localparam stim_row_t DIRECTED_ROWS [17] = '{
        // foreign id, data and close: dropped
        '{'{PKT_DATA,  8'hFF, 5'd1,  8'h01, 64'h0, 4'd8, 1'b0}, 1'b1, 1'b0},
        '{'{PKT_CLOSE, 8'h80, 5'd3,  8'h02, 64'h0, 4'd0, 1'b0}, 1'b1, 1'b0},
        // delivery queue full: data dropped
        '{'{PKT_DATA,  8'h00, 5'd1,  8'h03, ONES,  4'd8, 1'b1}, 1'b1, 1'b0},
        // outside the window on both sides: ack only
        '{'{PKT_DATA,  8'h00, 5'd0,  8'hFF, ONES,  4'd8, 1'b0}, 1'b1, 1'b1},
        '{'{PKT_DATA,  8'h00, 5'd17, 8'h00, 64'h0123_4567_89AB_CDEF, 4'd4, 1'b0},
          1'b1, 1'b1},
        // close outside the window keeps the link open; queue_full is moot
        '{'{PKT_CLOSE, 8'h00, 5'd31, 8'hAA, ONES,  4'd8, 1'b0}, 1'b1, 1'b1},
        '{'{PKT_CLOSE, 8'h00, 5'd20, 8'h55, 64'h0, 4'd0, 1'b1}, 1'b1, 1'b1},
        // buffer with oversize length, then a duplicate
        '{'{PKT_DATA,  8'h00, 5'd2,  8'h10, ONES,  4'd15, 1'b0}, 1'b0, 1'b0},
        '{'{PKT_DATA,  8'h00, 5'd2,  8'h11, 64'h0, 4'd3, 1'b0}, 1'b0, 1'b0},
        // far window edge, zero length
        '{'{PKT_DATA,  8'h00, 5'd16, 8'h12, ONES,  4'd0, 1'b0}, 1'b0, 1'b0},
        '{'{PKT_DATA,  8'h00, 5'd3,  8'h13, 64'h8000_0000_0000_0001, 4'd1, 1'b0},
          1'b0, 1'b0},
        // fill the gap: slide over 1, 2, 3
        '{'{PKT_DATA,  8'h00, 5'd1,  8'h14, 64'hFEDC_BA98_7654_3210, 4'd8, 1'b0},
          1'b0, 1'b0},
        '{'{PKT_DATA,  8'h00, 5'd5,  8'h15, 64'hA5A5_A5A5_A5A5_A5A5, 4'd4, 1'b0},
          1'b0, 1'b0},
        '{'{PKT_DATA,  8'h00, 5'd4,  8'h16, 64'h5A5A_5A5A_5A5A_5A5A, 4'd7, 1'b0},
          1'b0, 1'b0},
        // now behind the window: ack only
        '{'{PKT_DATA,  8'h00, 5'd3,  8'h17, ONES,  4'd8, 1'b0}, 1'b1, 1'b1},
        // newly opened edge slot, then a single-slot slide
        '{'{PKT_DATA,  8'h00, 5'd21, 8'h18, ONES,  4'd9, 1'b0}, 1'b0, 1'b0},
        '{'{PKT_DATA,  8'h00, 5'd6,  8'hFF, 64'h0, 4'd2, 1'b0}, 1'b0, 1'b0}
    };

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic [CONN_W-1:0]    cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;

    // Predictor copy of the window
    logic [7:0]  accept_conn;
    logic        win_expected [SEQ_SPACE];
    logic [63:0] slot_data [SEQ_SPACE];
    logic [3:0]  slot_len [SEQ_SPACE];
    logic [4:0]  win_lio;
    logic [4:0]  win_edge;
    logic        link_closed;

    result_t step_results [$];     // beats caused by the packet just modeled
    result_t pending_results [$];  // beats still owed by the unit
    logic [4:0] fill_plan [$];     // seqs of a whole-window refill in flight

    int  mismatch_count;
    int  cycle_count;
    int  src_gap_max;
    int  sink_stall_max;
    int  sink_hold_cycles;
    bit  closing_phase;

    selective_repeat_receive_window_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        aclk = 1'b0;
        #2.0;
        aclk = 1'b1;
        #2.0;
    end

    // ------------------------------------------------------------------
    // Window predictor
    // ------------------------------------------------------------------

    function automatic void clear_window_model();
        for (int i = 0; i < SEQ_SPACE; i++) begin
            win_expected[i] = 1'b0;
        end
        for (int i = 1; i <= WINDOW; i++) begin
            win_expected[i % SEQ_SPACE] = 1'b1;
        end
        win_lio     = '0;
        win_edge    = 5'(WINDOW % SEQ_SPACE);
        link_closed = 1'b0;
        accept_conn = '0;
    endfunction

    // In window when the distance past the last in-order seq lies in 1..span;
    // a zero span opens the whole sequence space.
    function automatic logic seq_in_window(input logic [4:0] s);
        logic [4:0] span;
        logic [4:0] seq_dist;
        span = win_edge - win_lio;
        seq_dist = s - win_lio;
        if (span == 5'd0) begin
            return 1'b1;
        end
        return (seq_dist >= 5'd1) && (seq_dist <= span);
    endfunction

    function automatic result_t ack_for(input packet_t p);
        result_t r;
        r = '{kind: RES_ACK, seq: p.seq, retry: p.retry, payload: '0, len: '0,
              closed: 1'b0, last: 1'b0};
        return r;
    endfunction

    // Advance the window by one packet and collect the beats it causes.
    function automatic void model_packet(input packet_t p);
        logic [63:0] kept;
        logic [3:0]  eff_len;
        int          slid;
        result_t     r;
        step_results.delete();
        if (p.conn != accept_conn) begin
            return;
        end
        if (p.kind == PKT_CLOSE) begin
            step_results.push_back(ack_for(p));
            if (seq_in_window(p.seq)) begin
                win_expected[p.seq] = 1'b0;
                link_closed = 1'b1;
            end
        end else begin
            if (link_closed || p.qfull) begin
                return;
            end
            step_results.push_back(ack_for(p));
            if (seq_in_window(p.seq) && win_expected[p.seq]) begin
                eff_len = (p.len > PAYLOAD_BYTES) ? 4'(PAYLOAD_BYTES) : p.len;
                kept = p.payload;
                for (int b = int'(eff_len); b < 8; b++) begin
                    kept[8*b +: 8] = 8'h00;
                end
                win_expected[p.seq] = 1'b0;
                slot_data[p.seq] = kept;
                slot_len[p.seq] = eff_len;
                if (p.seq == 5'(win_lio + 5'd1)) begin
                    slid = 0;
                    while (slid < WINDOW && !win_expected[5'(win_lio + 5'd1)]) begin
                        win_lio  = win_lio + 5'd1;
                        win_edge = win_edge + 5'd1;
                        win_expected[win_lio]  = 1'b0;
                        win_expected[win_edge] = 1'b1;
                        r = '{kind: RES_DELIVER, seq: win_lio, retry: '0,
                              payload: slot_data[win_lio], len: slot_len[win_lio],
                              closed: 1'b0, last: 1'b0};
                        step_results.push_back(r);
                        slid++;
                    end
                end
            end
        end
        foreach (step_results[i]) begin
            step_results[i].closed = link_closed;
        end
        if (step_results.size() > 0) begin
            step_results[step_results.size() - 1].last = 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------
    // Packet generation
    // ------------------------------------------------------------------

    // Queue every window slot past the next one in shuffled order, then the
    // next one last, so the final packet slides the whole window at once.
    function automatic void plan_window_refill();
        int order [$];
        int span_n;
        int j;
        int tmp;
        span_n = int'(5'(win_edge - win_lio));
        if (span_n == 0) begin
            span_n = SEQ_SPACE;
        end
        for (int d = 2; d <= span_n; d++) begin
            order.push_back(d);
        end
        for (int i = order.size() - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        foreach (order[i]) begin
            fill_plan.push_back(5'(win_lio + 5'(order[i])));
        end
        fill_plan.push_back(5'(win_lio + 5'd1));
    endfunction

    function automatic packet_t draw_packet();
        packet_t p;
        int      pick;
        int      span_n;
        span_n = int'(5'(win_edge - win_lio));
        if (span_n == 0) begin
            span_n = SEQ_SPACE;
        end
        p.kind    = PKT_DATA;
        p.conn    = accept_conn;
        p.retry   = 8'($urandom);
        p.payload = {$urandom, $urandom};
        p.len     = 4'($urandom_range(0, 15));
        p.qfull   = 1'b0;
        p.seq     = 5'(win_lio + 5'd1 + 5'($urandom_range(0, span_n - 1)));

        // After the link closes: any mix, mostly on our id
        if (closing_phase) begin
            p.kind  = 1'($urandom_range(0, 1));
            p.qfull = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 2) == 0) begin
                p.seq = 5'($urandom);
            end
            if ($urandom_range(0, 7) == 0) begin
                p.conn = accept_conn ^ 8'($urandom_range(1, 255));
            end
            return p;
        end

        if (fill_plan.size() > 0) begin
            p.seq = fill_plan.pop_front();
            return p;
        end

        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            // fill the next slot: drives slides
            p.seq = 5'(win_lio + 5'd1);
        end else if (pick < 60) begin
            // random in-window slot, already set up above
        end else if (pick < 66) begin
            p.seq = 5'($urandom);
        end else if (pick < 71) begin
            p.qfull = 1'b1;
        end else if (pick < 76) begin
            p.kind = 1'($urandom_range(0, 1));
            p.seq  = 5'($urandom);
            p.conn = accept_conn ^ 8'($urandom_range(1, 255));
        end else if (pick < 81) begin
            // close behind or past the window: ack, link stays open
            p.kind = PKT_CLOSE;
            p.seq  = 5'(win_lio + 5'(span_n + $urandom_range(1, SEQ_SPACE - span_n)));
        end else if (pick < 84) begin
            plan_window_refill();
            p.seq = fill_plan.pop_front();
        end else begin
            p.payload = $urandom_range(0, 1) ? ONES : 64'h0;
            case ($urandom_range(0, 2))
                0: begin
                    p.len = 4'd0;
                end
                1: begin
                    p.len = 4'd8;
                end
                default: begin
                    p.len = 4'd15;
                end
            endcase
        end
        return p;
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack_packet(input packet_t p);
        logic [S_TDATA_W-1:0] word;
        word = '0;
        word[S_CONN_LSB  +: CONN_W]  = p.conn;
        word[S_SEQ_LSB   +: SEQ_F_W] = p.seq;
        word[S_RETRY_LSB +: RETRY_W] = p.retry;
        word[S_PAY_LSB   +: PAY_F_W] = p.payload;
        word[S_LEN_LSB   +: LEN_W]   = p.len;
        word[S_QFULL_BIT]            = p.qfull;
        return word;
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one packet after a random gap, hold it until the unit takes the
    // beat, then log what that beat owes us. Entered and left at a clock edge.
    task automatic send_packet(input packet_t p, input logic typed, input logic typed_ack);
        int gap;
        gap = (src_gap_max == 0) ? 0 : $urandom_range(0, src_gap_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= p.kind;
        s_tdata  <= pack_packet(p);
        do @(posedge aclk); while (s_tready !== 1'b1);
        model_packet(p);
        if (typed) begin
            // hand-typed outcome replaces the predicted one
            if (typed_ack) begin
                pending_results.push_back('{kind: RES_ACK, seq: p.seq, retry: p.retry,
                                            payload: '0, len: '0, closed: 1'b0,
                                            last: 1'b1});
            end
        end else begin
            foreach (step_results[i]) begin
                pending_results.push_back(step_results[i]);
            end
        end
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++) begin
            send_packet(draw_packet(), 1'b0, 1'b0);
        end
    endtask

    // Drop valid, wait out every owed beat, then let a dropped packet finish.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_connection_id(input logic [7:0] id);
        cfg_we    <= 1'b1;
        cfg_wdata <= id;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        accept_conn = id;
    endtask

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        packet_t shut;
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        mismatch_count   = 0;
        sink_hold_cycles = 0;
        src_gap_max      = GAP_MAX;
        sink_stall_max   = GAP_MAX;
        closing_phase    = 1'b0;
        clear_window_model();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed rows on the reset id
        foreach (DIRECTED_ROWS[i]) begin
            send_packet(DIRECTED_ROWS[i].pkt, DIRECTED_ROWS[i].typed,
                        DIRECTED_ROWS[i].typed_ack);
        end
        wait_idle();

        // Top id, random gaps on both sides
        write_connection_id(8'hFF);
        send_random(120);
        wait_idle();

        // Back to back with a long receiver hold: the unit must back up and
        // stall its input while we keep offering.
        write_connection_id(8'($urandom_range(1, 254)));
        src_gap_max      = 0;
        sink_stall_max   = 0;
        sink_hold_cycles = HOLD_CYCLES;
        send_random(100);
        wait_idle();

        // Bottom id, random gaps again
        src_gap_max    = GAP_MAX;
        sink_stall_max = GAP_MAX;
        write_connection_id(8'h00);
        send_random(150);
        wait_idle();

        // Last id: normal traffic, then close inside the window and keep
        // sending so drops and acks on a closed link get exercised.
        write_connection_id(8'($urandom));
        send_random(60);
        fill_plan.delete();
        closing_phase = 1'b1;
        shut = draw_packet();
        shut.kind  = PKT_CLOSE;
        shut.conn  = accept_conn;
        shut.seq   = 5'(win_lio + 5'd1 + 5'($urandom_range(0, WINDOW - 1)));
        send_packet(shut, 1'b0, 1'b0);
        send_random(25);
        wait_idle();

        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("selective_repeat_receive_window_unit: match");
        end else begin
            $display("selective_repeat_receive_window_unit: mismatch");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver side: random stall before each beat, plus one long hold
    // ------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        forever begin
            if (sink_hold_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (sink_hold_cycles) @(posedge aclk);
                sink_hold_cycles = 0;
            end
            stall = (sink_stall_max == 0) ? 0 : $urandom_range(0, sink_stall_max);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
        end
    end

    // ------------------------------------------------------------------
    // Result checker: compare each accepted beat with the oldest one owed
    // ------------------------------------------------------------------
    task automatic flag_result(input string why, input result_t want, input result_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
            $display("[%0t] %s", $realtime, why);
            $display("  want kind=%0d seq=%0d retry=%h payload=%h len=%0d closed=%0d last=%0d",
                     want.kind, want.seq, want.retry, want.payload, want.len,
                     want.closed, want.last);
            $display("  got  kind=%0d seq=%0d retry=%h payload=%h len=%0d closed=%0d last=%0d",
                     got.kind, got.seq, got.retry, got.payload, got.len,
                     got.closed, got.last);
        end
    endtask

    always @(posedge aclk) begin : result_check
        result_t got;
        result_t want;
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            got.kind    = m_tuser;
            got.seq     = m_tdata[M_SEQ_LSB   +: SEQ_F_W];
            got.retry   = m_tdata[M_RETRY_LSB +: RETRY_W];
            got.payload = m_tdata[M_PAY_LSB   +: PAY_F_W];
            got.len     = m_tdata[M_LEN_LSB   +: LEN_W];
            got.closed  = m_tdata[M_CLOSED_BIT];
            got.last    = m_tlast;
            if (pending_results.size() == 0) begin
                flag_result("result beat with nothing owed", '0, got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    flag_result("result beat differs", want, got);
                end
            end
        end
    end

    // Watchdog
    initial cycle_count = 0;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("selective_repeat_receive_window_unit: mismatch");
            $finish;
        end
    end

endmodule
